>>> rtl/rtcv_pkg.sv
`timescale 1ns / 1ps
package rtcv_pkg;

  localparam int HistoryDepth = 15;
  localparam int MaxLen       = 64;

  localparam logic [7:0] ChSpace = 8'h20;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_COPY_RD,
    ST_COPY_WR,
    ST_CMP_K,
    ST_CMP_RD,
    ST_CMP_CK,
    ST_SCORE,
    ST_OUT_RD,
    ST_OUT_LD,
    ST_OUT_WAIT
  } state_e;

  function automatic logic is_punct(input logic [7:0] b);
    logic r;
    case (b)
      8'h2E, 8'h2C, 8'h21, 8'h3F, 8'h26, 8'h2D,
      8'h27, 8'h28, 8'h29, 8'h3A, 8'h24, 8'h2F: r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  function automatic logic is_allowed(input logic [7:0] b);
    logic r;
    r = 1'b0;
    if (b >= 8'h30 && b <= 8'h39) r = 1'b1;
    if (b >= 8'h41 && b <= 8'h5A) r = 1'b1;
    if (b >= 8'h61 && b <= 8'h7A) r = 1'b1;
    if (is_punct(b)) r = 1'b1;
    case (b)
      8'h20, 8'hC3, 8'hA5, 8'hA4, 8'hB6, 8'h85, 8'h84, 8'h96: r = 1'b1;
      default: ;
    endcase
    return r;
  endfunction

endpackage

>>> rtl/rds_text_consensus_voter.sv
`timescale 1ns / 1ps
// RDS text consensus voter.
// Input stream: s_axis_tdata carries one received text byte, s_axis_tlast marks
// the final byte of a string, s_axis_tuser = 1 is a clear command (retune) that
// empties the history and drops any partial string.
// A byte that is not the last one is taken and ready stays high, so such
// bytes can follow back to back. On the last byte the block goes busy: it
// copies the string into the history memory, compares it against every
// stored string of the same length, scores all stored entries and then
// streams the best string, one item per byte.
// A string that filters to nothing gives one no_text item instead.
// The history memory has a single read port.
// A stalled receiver holds the output item; no input is taken until the last
// result item is delivered.
// Reset empties the history and the partial string; memories are not cleared.
module rds_text_consensus_voter #(
  parameter int HISTORY_DEPTH = rtcv_pkg::HistoryDepth,
  parameter int MAX_LEN       = rtcv_pkg::MaxLen
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // in_byte[7:0]
  input  logic        s_axis_tlast,
  input  logic        s_axis_tuser,   // cmd
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // out_byte[7:0], best_score[14:8], zero[15]
  output logic        m_axis_tlast,
  output logic        m_axis_tuser    // no_text
);

  localparam int D  = HISTORY_DEPTH;
  localparam int L  = MAX_LEN;
  localparam int SW = (D > 1) ? $clog2(D) : 1;
  localparam int FW = $clog2(D + 1);
  localparam int LW = $clog2(L + 1);
  localparam int IW = $clog2(L);
  localparam int AW = $clog2(D * L);

  rtcv_pkg::state_e state_q, state_d;

  logic [LW-1:0] inc_len_q, inc_len_d;
  logic [LW-1:0] inc_punct_q, inc_punct_d;
  logic          last_sp_q, last_sp_d;
  logic [LW-1:0] new_len_q, new_len_d;
  logic [SW-1:0] head_q, head_d;
  logic [FW-1:0] fill_q, fill_d;
  logic [D-1:0]  valid_q, valid_d;
  logic [SW-1:0] slot_q, slot_d;
  logic [SW-1:0] k_q, k_d;
  logic [IW-1:0] i_q, i_d;
  logic [FW-1:0] age_q, age_d;
  logic [6:0]    best_q, best_d;
  logic [SW-1:0] best_slot_q, best_slot_d;
  logic          first_q, first_d;

  logic [LW-1:0] len_arr_q [D];
  logic [LW-1:0] punct_arr_q [D];
  logic [D-1:0]  eq_q [D];

  logic          out_valid_q, out_valid_d;
  logic [7:0]    out_byte_q, out_byte_d;
  logic          out_last_q, out_last_d;
  logic          out_none_q, out_none_d;
  logic [6:0]    out_score_q, out_score_d;

  // side effects on the small arrays
  logic          push;
  logic          eq_set;
  logic          eq_val;

  logic          inc_we;
  logic [IW-1:0] inc_raddr;
  logic [7:0]    inc_rdata;
  logic          hist_we;
  logic [AW-1:0] hist_waddr, hist_raddr;
  logic [7:0]    hist_rdata;

  logic [SW-1:0] idx;
  logic [LW-1:0] idx_len;
  logic [LW-1:0] idx_punct;
  logic [6:0]    score;

  logic          in_fire;
  logic          keep;
  logic [LW-1:0] len_tot;
  logic [LW-1:0] punct_tot;
  logic          sp_tot;

  assign in_fire   = s_axis_tvalid && s_axis_tready;
  assign keep      = rtcv_pkg::is_allowed(s_axis_tdata) && (inc_len_q < LW'(L));
  assign len_tot   = inc_len_q + LW'(keep);
  assign punct_tot = inc_punct_q + LW'(keep && rtcv_pkg::is_punct(s_axis_tdata));
  assign sp_tot    = keep ? (s_axis_tdata == rtcv_pkg::ChSpace) : last_sp_q;
  assign inc_we    = in_fire && !s_axis_tuser && keep;

  rtcv_ram #(.Width(8), .Depth(L)) u_inc_ram (
    .clk_i   (clk_i),
    .we_i    (inc_we),
    .waddr_i (inc_len_q[IW-1:0]),
    .wdata_i (s_axis_tdata),
    .raddr_i (inc_raddr),
    .rdata_o (inc_rdata)
  );

  rtcv_ram #(.Width(8), .Depth(D * L)) u_hist_ram (
    .clk_i   (clk_i),
    .we_i    (hist_we),
    .waddr_i (hist_waddr),
    .wdata_i (inc_rdata),
    .raddr_i (hist_raddr),
    .rdata_o (hist_rdata)
  );

  always_comb begin
    unique case (state_q)
      rtcv_pkg::ST_SCORE: idx = slot_q;
      rtcv_pkg::ST_OUT_RD, rtcv_pkg::ST_OUT_LD, rtcv_pkg::ST_OUT_WAIT: idx = best_slot_q;
      default: idx = k_q;
    endcase
  end
  assign idx_len   = len_arr_q[idx];
  assign idx_punct = punct_arr_q[idx];
  assign score = 7'(idx_len - idx_punct) + 7'($countones(eq_q[idx] & valid_q));

  assign hist_waddr = AW'(slot_q) * AW'(L) + AW'(i_q);

  always_comb begin
    state_d     = state_q;
    inc_len_d   = inc_len_q;
    inc_punct_d = inc_punct_q;
    last_sp_d   = last_sp_q;
    new_len_d   = new_len_q;
    head_d      = head_q;
    fill_d      = fill_q;
    valid_d     = valid_q;
    slot_d      = slot_q;
    k_d         = k_q;
    i_d         = i_q;
    age_d       = age_q;
    best_d      = best_q;
    best_slot_d = best_slot_q;
    first_d     = first_q;
    out_valid_d = out_valid_q;
    out_byte_d  = out_byte_q;
    out_last_d  = out_last_q;
    out_none_d  = out_none_q;
    out_score_d = out_score_q;
    push        = 1'b0;
    eq_set      = 1'b0;
    eq_val      = 1'b0;
    hist_we     = 1'b0;
    inc_raddr   = i_q;
    hist_raddr  = AW'(k_q) * AW'(L) + AW'(i_q);
    s_axis_tready = 1'b0;

    unique case (state_q)
      rtcv_pkg::ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (in_fire) begin
          if (s_axis_tuser) begin
            fill_d    = '0;
            head_d    = '0;
            valid_d   = '0;
            inc_len_d = '0;
            inc_punct_d = '0;
            last_sp_d = 1'b0;
          end else begin
            if (keep) begin
              inc_len_d   = len_tot;
              inc_punct_d = punct_tot;
              last_sp_d   = sp_tot;
            end
            if (s_axis_tlast) begin
              inc_len_d   = '0;
              inc_punct_d = '0;
              last_sp_d   = 1'b0;
              new_len_d   = len_tot - LW'(len_tot != '0 && sp_tot);
              if (new_len_d == '0) begin
                out_valid_d = 1'b1;
                out_byte_d  = '0;
                out_last_d  = 1'b1;
                out_none_d  = 1'b1;
                out_score_d = '0;
                state_d     = rtcv_pkg::ST_OUT_WAIT;
              end else begin
                push    = 1'b1;
                slot_d  = (head_q == '0) ? SW'(D - 1) : head_q - SW'(1);
                head_d  = slot_d;
                if (fill_q < FW'(D)) fill_d = fill_q + FW'(1);
                valid_d[slot_d] = 1'b1;
                i_d     = '0;
                state_d = rtcv_pkg::ST_COPY_RD;
              end
            end
          end
        end
      end
      rtcv_pkg::ST_COPY_RD: state_d = rtcv_pkg::ST_COPY_WR;
      rtcv_pkg::ST_COPY_WR: begin
        hist_we = 1'b1;
        if (LW'(i_q) == new_len_q - LW'(1)) begin
          k_d     = '0;
          state_d = rtcv_pkg::ST_CMP_K;
        end else begin
          i_d     = i_q + IW'(1);
          state_d = rtcv_pkg::ST_COPY_RD;
        end
      end
      rtcv_pkg::ST_CMP_K: begin
        i_d = '0;
        if (k_q == slot_q || !valid_q[k_q] || idx_len != new_len_q) begin
          eq_set = (k_q != slot_q);
          eq_val = 1'b0;
          if (k_q == SW'(D - 1)) begin
            age_d   = '0;
            slot_d  = head_q;
            first_d = 1'b1;
            state_d = rtcv_pkg::ST_SCORE;
          end else begin
            k_d = k_q + SW'(1);
          end
        end else begin
          state_d = rtcv_pkg::ST_CMP_RD;
        end
      end
      rtcv_pkg::ST_CMP_RD: state_d = rtcv_pkg::ST_CMP_CK;
      rtcv_pkg::ST_CMP_CK: begin
        if (inc_rdata != hist_rdata || LW'(i_q) == new_len_q - LW'(1)) begin
          eq_set = 1'b1;
          eq_val = (inc_rdata == hist_rdata);
          if (k_q == SW'(D - 1)) begin
            age_d   = '0;
            slot_d  = head_q;
            first_d = 1'b1;
            state_d = rtcv_pkg::ST_SCORE;
          end else begin
            k_d     = k_q + SW'(1);
            state_d = rtcv_pkg::ST_CMP_K;
          end
        end else begin
          i_d     = i_q + IW'(1);
          state_d = rtcv_pkg::ST_CMP_RD;
        end
      end
      rtcv_pkg::ST_SCORE: begin
        // slot_q walks the ages from newest to oldest
        if (first_q || score > best_q) begin
          best_d      = score;
          best_slot_d = slot_q;
        end
        first_d = 1'b0;
        slot_d  = (slot_q == SW'(D - 1)) ? '0 : slot_q + SW'(1);
        age_d   = age_q + FW'(1);
        if (age_q == fill_q - FW'(1)) begin
          i_d     = '0;
          state_d = rtcv_pkg::ST_OUT_RD;
        end
      end
      rtcv_pkg::ST_OUT_RD: begin
        hist_raddr = AW'(best_slot_q) * AW'(L) + AW'(i_q);
        state_d    = rtcv_pkg::ST_OUT_LD;
      end
      rtcv_pkg::ST_OUT_LD: begin
        out_valid_d = 1'b1;
        out_byte_d  = hist_rdata;
        out_last_d  = (LW'(i_q) == idx_len - LW'(1));
        out_none_d  = 1'b0;
        out_score_d = best_q;
        state_d     = rtcv_pkg::ST_OUT_WAIT;
      end
      rtcv_pkg::ST_OUT_WAIT: begin
        if (m_axis_tready) begin
          out_valid_d = 1'b0;
          if (out_last_q) begin
            state_d = rtcv_pkg::ST_IDLE;
          end else begin
            i_d     = i_q + IW'(1);
            state_d = rtcv_pkg::ST_OUT_RD;
          end
        end
      end
      default: state_d = rtcv_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rtcv_pkg::ST_IDLE;
      inc_len_q   <= '0;
      inc_punct_q <= '0;
      last_sp_q   <= 1'b0;
      head_q      <= '0;
      fill_q      <= '0;
      valid_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      inc_len_q   <= inc_len_d;
      inc_punct_q <= inc_punct_d;
      last_sp_q   <= last_sp_d;
      head_q      <= head_d;
      fill_q      <= fill_d;
      valid_q     <= valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    new_len_q   <= new_len_d;
    slot_q      <= slot_d;
    k_q         <= k_d;
    i_q         <= i_d;
    age_q       <= age_d;
    best_q      <= best_d;
    best_slot_q <= best_slot_d;
    first_q     <= first_d;
    out_byte_q  <= out_byte_d;
    out_last_q  <= out_last_d;
    out_none_q  <= out_none_d;
    out_score_q <= out_score_d;
    if (push) begin
      len_arr_q[slot_d]   <= new_len_d;
      punct_arr_q[slot_d] <= punct_tot;
      for (int j = 0; j < D; j++) begin
        eq_q[slot_d][j] <= (j == int'(slot_d));
        eq_q[j][slot_d] <= (j == int'(slot_d));
      end
    end
    if (eq_set) begin
      eq_q[slot_q][k_q] <= eq_val;
      eq_q[k_q][slot_q] <= eq_val;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_score_q, out_byte_q};
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tuser  = out_none_q;

endmodule

>>> rtl/rtcv_ram.sv
`timescale 1ns / 1ps
module rtcv_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> rtl/rtcv_checker.sv
`timescale 1ns / 1ps
module rtcv_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic        m_axis_tlast,
  input logic        m_axis_tuser
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("output item dropped under stall");

  a_none_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
    else $error("no_text item is not a single item");

  a_none_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == 16'h0000)
    else $error("no_text item carries data");

  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(m_axis_tvalid && s_axis_tready))
    else $error("input taken while a result is pending");

endmodule

bind rds_text_consensus_voter rtcv_checker u_rtcv_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast),
  .m_axis_tuser  (m_axis_tuser)
);

>>> tb/rds_text_consensus_voter_checker.sv
`timescale 1ns / 1ps
module rds_text_consensus_voter_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,
  input  logic        s_axis_tlast,
  input  logic        s_axis_tuser,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [15:0] m_axis_tdata,
  input  logic        m_axis_tlast,
  input  logic        m_axis_tuser,
  output int          fail_cnt_o,
  output int          pending_o,
  output int          text_cnt_o,
  output int          empty_cnt_o
);
  localparam int HistDepth = rtcv_pkg::HistoryDepth;
  localparam int StrLen    = rtcv_pkg::MaxLen;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       last;
    logic       no_text;
    logic [6:0] score;
  } voted_item_t;

  voted_item_t voted_q[$];

  logic [7:0] hist_text[HistDepth][StrLen];
  int         hist_len[HistDepth];
  int         hist_punct[HistDepth];
  int         hist_fill, hist_head;
  logic [7:0] rx_text[StrLen];
  int         rx_len;

  function automatic bit punct_byte(logic [7:0] b);
    case (b)
      ".", ",", "!", "?", "&", "-", "'", "(", ")", ":", "$", "/": return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic bit kept_byte(logic [7:0] b);
    if ((b >= "0" && b <= "9") || (b >= "A" && b <= "Z") || (b >= "a" && b <= "z"))
      return 1'b1;
    if (punct_byte(b)) return 1'b1;
    case (b)
      8'h20, 8'hC3, 8'hA5, 8'hA4, 8'hB6, 8'h85, 8'h84, 8'h96: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic bit same_entry(int a, int b);
    if (hist_len[a] != hist_len[b]) return 1'b0;
    for (int k = 0; k < hist_len[a]; k++)
      if (hist_text[a][k] != hist_text[b][k]) return 1'b0;
    return 1'b1;
  endfunction

  task automatic take_byte(logic clr, logic [7:0] b, logic last);
    int len, slot, p, best, best_slot, sc, si;
    voted_item_t it;
    if (clr) begin
      hist_fill = 0;
      hist_head = 0;
      rx_len = 0;
      return;
    end
    if (kept_byte(b) && rx_len < StrLen) begin
      rx_text[rx_len] = b;
      rx_len++;
    end
    if (!last) return;
    len = rx_len;
    rx_len = 0;
    if (len > 0 && rx_text[len-1] == 8'h20) len--;
    if (len == 0) begin
      it = '{text_byte: 8'h00, last: 1'b1, no_text: 1'b1, score: 7'd0};
      voted_q.push_back(it);
      empty_cnt_o++;
      return;
    end
    slot = (hist_head + HistDepth - 1) % HistDepth;
    hist_head = slot;
    if (hist_fill < HistDepth) hist_fill++;
    p = 0;
    for (int k = 0; k < len; k++) begin
      hist_text[slot][k] = rx_text[k];
      if (punct_byte(rx_text[k])) p++;
    end
    hist_len[slot] = len;
    hist_punct[slot] = p;
    best = -1;
    best_slot = slot;
    for (int i = 0; i < hist_fill; i++) begin
      si = (hist_head + i) % HistDepth;
      sc = hist_len[si] - hist_punct[si];
      for (int j = 0; j < hist_fill; j++)
        if (same_entry(si, (hist_head + j) % HistDepth)) sc++;
      if (sc > best) begin
        best = sc;
        best_slot = si;
      end
    end
    for (int k = 0; k < hist_len[best_slot]; k++) begin
      it.text_byte = hist_text[best_slot][k];
      it.last = (k == hist_len[best_slot] - 1);
      it.no_text = 1'b0;
      it.score = best[6:0];
      voted_q.push_back(it);
    end
    text_cnt_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    voted_item_t want;
    int errs;
    errs = 0;
    if (!rst_ni) begin
      hist_fill = 0;
      hist_head = 0;
      rx_len = 0;
      voted_q.delete();
      fail_cnt_o <= 0;
      text_cnt_o = 0;
      empty_cnt_o = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) take_byte(s_axis_tuser, s_axis_tdata, s_axis_tlast);
      if (m_axis_tvalid && m_axis_tready) begin
        if (voted_q.size() == 0) begin
          $error("unexpected output item: data %h", m_axis_tdata);
          errs++;
        end else begin
          want = voted_q[0];
          voted_q.delete(0);
          if (m_axis_tdata[7:0] !== want.text_byte) begin
            $error("out_byte: expected %h, actual %h", want.text_byte, m_axis_tdata[7:0]);
            errs++;
          end
          if (m_axis_tdata[14:8] !== want.score) begin
            $error("best_score: expected %0d, actual %0d", want.score, m_axis_tdata[14:8]);
            errs++;
          end
          if (m_axis_tlast !== want.last) begin
            $error("out_last: expected %b, actual %b", want.last, m_axis_tlast);
            errs++;
          end
          if (m_axis_tuser !== want.no_text) begin
            $error("no_text: expected %b, actual %b", want.no_text, m_axis_tuser);
            errs++;
          end
        end
      end
      if (errs != 0) fail_cnt_o <= fail_cnt_o + errs;
    end
    pending_o = voted_q.size();
  end
endmodule

>>> tb/rds_text_consensus_voter_tb.sv
`timescale 1ns / 1ps
module rds_text_consensus_voter_tb;
  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic        s_axis_tlast = 1'b0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        m_axis_tuser;
  int          fail_cnt, pending, text_cnt, empty_cnt;
  int          cycle_cnt = 0;
  int          byte_cnt = 0;
  bit          hold_off = 1'b0;
  bit          stim_done = 1'b0;

  localparam int CycleLimit = 2_000_000;
  localparam logic CmdText  = 1'b0;
  localparam logic CmdClear = 1'b1;

  // a few phrases so repeats pile up votes
  logic [7:0] phrase[4][12];

  rds_text_consensus_voter DUT (.*);

  rds_text_consensus_voter_checker u_checker (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tlast,
    .s_axis_tuser, .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast,
    .m_axis_tuser, .fail_cnt_o(fail_cnt), .pending_o(pending), .text_cnt_o(text_cnt),
    .empty_cnt_o(empty_cnt)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  function automatic int gap_len();
    if ($urandom_range(0, 19) == 0) return $urandom_range(20, 60);
    if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
    return 0;
  endfunction

  // receiver: random stalls, one long hold-off on request
  always @(posedge clk_i) begin
    if (hold_off) m_axis_tready <= 1'b0;
    else if ($urandom_range(0, 9) < 7 || cycle_cnt % 2000 < 400) m_axis_tready <= 1'b1;
    else m_axis_tready <= ($urandom_range(0, 19) == 0) ? 1'b0 : 1'($urandom_range(0, 1));
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic send(logic cmd, logic [7:0] b, logic last);
    int g;
    g = gap_len();
    if (g > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= last;
    s_axis_tuser  <= cmd;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    byte_cnt++;
  endtask

  task automatic idle_until_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic send_phrase(int p, int len, bit noisy);
    logic [7:0] b;
    for (int k = 0; k < len; k++) begin
      b = phrase[p][k];
      if (noisy && $urandom_range(0, 7) == 0) b = 8'($urandom_range(0, 255));
      send(CmdText, b, k == len - 1);
    end
  endtask

  task automatic send_random_string(int len);
    for (int k = 0; k < len; k++) send(CmdText, 8'($urandom_range(0, 255)), k == len - 1);
  endtask

  initial begin
    phrase[0] = '{"R", "o", "c", "k", " ", "F", "M", "!", " ", "H", "i", " "};
    phrase[1] = '{8'hC3, 8'hA5, "s", "a", "-", "9", "9", "$", "/", "(", ")", "'"};
    phrase[2] = '{"N", "e", "w", "s", ":", "z", "Z", "0", "?", "&", ".", ","};
    phrase[3] = '{8'hC3, 8'h84, 8'hC3, 8'hB6, 8'h85, 8'hA4, 8'h96, "a", "z", "A", "Z", " "};
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: NUL only (empty after filtering), single space, trailing space, bit extremes
    send(CmdText, 8'h00, 1'b1);
    send(CmdText, 8'h20, 1'b1);
    send(CmdText, 8'hFF, 1'b0);
    send(CmdText, "A", 1'b0);
    send(CmdText, 8'h20, 1'b1);
    send(CmdText, 8'h7F, 1'b1);
    send_phrase(0, 12, 0);
    send_phrase(3, 12, 0);
    // clear drops the partial string and history; its data bits are don't-care
    send(CmdText, "x", 1'b0);
    send(CmdClear, 8'hFF, 1'b1);
    send(CmdText, "q", 1'b1);
    idle_until_drained();

    // overlong string, truncated; the cut ends in space so trim hits the cut string
    for (int k = 0; k < 70; k++) send(CmdText, (k == 63) ? 8'h20 : "M", k == 69);
    send_phrase(1, 12, 0);

    // long receiver hold-off while the sender keeps offering
    hold_off = 1'b1;
    fork
      begin
        repeat (300) @(posedge clk_i);
        hold_off = 1'b0;
      end
      begin
        for (int r = 0; r < 4; r++) send_phrase(2, 12, 0);
      end
    join

    while (byte_cnt < 185) begin
      case ($urandom_range(0, 9))
        0: send_random_string($urandom_range(1, 10));
        1: send(CmdClear, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        2: send(CmdText, 8'($urandom_range(0, 255)), 1'b1);
        default: send_phrase($urandom_range(0, 3), $urandom_range(1, 12),
                             $urandom_range(0, 3) == 0);
      endcase
      if ($urandom_range(0, 29) == 0) idle_until_drained();
    end
    // a full-length string of random bytes; only its allowed bytes reach history
    send_random_string(64);
    send(CmdText, "e", 1'b1);
    idle_until_drained();
    repeat (200) @(posedge clk_i);
    stim_done = 1'b1;
  end

  always @(posedge clk_i) begin
    if (stim_done) begin
      $display("Covered %0d bytes: %0d voted strings, %0d empty strings.",
               byte_cnt, text_cnt, empty_cnt);
      if (fail_cnt == 0 && pending == 0) begin
        $display("TB_OK");
      end else begin
        $display("TB_ERROR");
      end
      $finish;
    end
  end
endmodule
